/* hw/rtl/wms_pkg.sv */
// Shared types, codes and helpers of the waypoint mission sequencer.
`timescale 1ns / 1ps

package wms_pkg;

   localparam int COORD_W  = 24;
   localparam int RADIUS_W = 50;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef enum logic [1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_APPEND   = 2'd1,
      CMD_ACTIVATE = 2'd2,
      CMD_TICK     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_XYZ  = 2'd0,
      KIND_ALT  = 2'd1,
      KIND_VEL  = 2'd2,
      KIND_DONE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_TAKEOFF_TARGET_Z = 2'd0,
      CSR_TAKEOFF_DONE_Z   = 2'd1,
      CSR_REACH_RADIUS_SQ  = 2'd2,
      CSR_DESCENT_RATE     = 2'd3
   } csr_reg_type;

   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_TAKEOFF = 6'b000010,
      PH_NAV     = 6'b000100,
      PH_HOME    = 6'b001000,
      PH_LAND    = 6'b010000,
      PH_DONE    = 6'b100000
   } phase_type;

   localparam logic [2:0] PCODE_IDLE    = 3'd0;
   localparam logic [2:0] PCODE_TAKEOFF = 3'd1;
   localparam logic [2:0] PCODE_NAV     = 3'd2;
   localparam logic [2:0] PCODE_HOME    = 3'd3;
   localparam logic [2:0] PCODE_LAND    = 3'd4;
   localparam logic [2:0] PCODE_DONE    = 3'd5;

   localparam coord_type             RST_TAKEOFF_TARGET_Z = -24'sd2560;
   localparam coord_type             RST_TAKEOFF_DONE_Z   = -24'sd2432;
   localparam logic [RADIUS_W-1:0]   RST_REACH_RADIUS_SQ  = 50'd16384;
   localparam coord_type             RST_DESCENT_RATE     = 24'sd128;

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] code;
      case (ph)
         PH_IDLE:    code = PCODE_IDLE;
         PH_TAKEOFF: code = PCODE_TAKEOFF;
         PH_NAV:     code = PCODE_NAV;
         PH_HOME:    code = PCODE_HOME;
         PH_LAND:    code = PCODE_LAND;
         PH_DONE:    code = PCODE_DONE;
         default:    code = PCODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

/* hw/rtl/waypoint_mission_sequencer.sv */
// Top level of the waypoint mission sequencer: input stage, phase machine, result stage.
// Path: a word goes from the input register to the result register that drives rsp_valid.
// Throughput: one word per cycle unless a held result stalls it; the limit is the single
// step logic between the two registers, fed by one registered read of the waypoint RAM.
// Reset: phase idle, list empty, index and takeoff flag zero, registers at defaults.
`timescale 1ns / 1ps

module waypoint_mission_sequencer #(
   parameter int MAX_WAYPOINTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   input  logic signed [23:0] req_pos_z,
   input  logic               req_landed,
   input  logic signed [23:0] req_wp_x,
   input  logic signed [23:0] req_wp_y,
   input  logic signed [23:0] req_wp_z,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic signed [23:0] rsp_set_x,
   output logic signed [23:0] rsp_set_y,
   output logic signed [23:0] rsp_set_z,
   output logic [2:0]         rsp_phase,
   output logic [4:0]         rsp_current_index,
   // configuration writes
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [49:0]        csr_wdata
);
   import wms_pkg::*;

   localparam int IDX_W  = $clog2(MAX_WAYPOINTS + 1);
   localparam int ADDR_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam logic [IDX_W-1:0] WP_LIMIT = IDX_W'(MAX_WAYPOINTS);

   // ------------------------------------------------------------------
   // Handshake: the input stage moves on whenever the result stage is
   // free or being drained this cycle, so a new word can enter every cycle.
   // ------------------------------------------------------------------
   logic in_valid_ff, in_valid_in;
   logic advance;
   logic take;

   assign advance   = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   // input stage payload
   cmd_type   in_cmd_ff;
   point_type in_pos_ff;
   logic      in_landed_ff;
   point_type in_wp_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_cmd_ff    <= cmd_type'(req_command);
         in_pos_ff    <= '{x: req_pos_x, y: req_pos_y, z: req_pos_z};
         in_landed_ff <= req_landed;
         in_wp_ff     <= '{x: req_wp_x, y: req_wp_y, z: req_wp_z};
      end
   end

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   coord_type             cfg_target_z_ff;
   coord_type             cfg_done_z_ff;
   logic [RADIUS_W-1:0]   cfg_radius_sq_ff;
   coord_type             cfg_descent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_target_z_ff  <= RST_TAKEOFF_TARGET_Z;
         cfg_done_z_ff    <= RST_TAKEOFF_DONE_Z;
         cfg_radius_sq_ff <= RST_REACH_RADIUS_SQ;
         cfg_descent_ff   <= RST_DESCENT_RATE;
      end else if (csr_we) begin
         case (csr_reg_type'(csr_index))
            CSR_TAKEOFF_TARGET_Z: cfg_target_z_ff  <= csr_wdata[COORD_W-1:0];
            CSR_TAKEOFF_DONE_Z:   cfg_done_z_ff    <= csr_wdata[COORD_W-1:0];
            CSR_REACH_RADIUS_SQ:  cfg_radius_sq_ff <= csr_wdata[RADIUS_W-1:0];
            CSR_DESCENT_RATE:     cfg_descent_ff   <= csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Mission state
   // ------------------------------------------------------------------
   phase_type        phase_ff, phase_in;
   logic             issued_ff, issued_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [IDX_W-1:0] count_ff, count_in;

   // ------------------------------------------------------------------
   // Waypoint store. The read address follows the next target index, so
   // the registered read data matches the index the next word will see.
   // A write to that same address in the same cycle is forwarded.
   // ------------------------------------------------------------------
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   point_type         ram_q;
   logic              byp_hit_ff;
   point_type         byp_data_ff;
   point_type         wp_cur;

   assign wr_addr = count_ff[ADDR_W-1:0];
   assign rd_addr = index_in[ADDR_W-1:0];

   wms_ram #(
      .WIDTH ($bits(point_type)),
      .DEPTH (MAX_WAYPOINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_wp_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      byp_hit_ff  <= wr_en && (wr_addr == rd_addr);
      byp_data_ff <= in_wp_ff;
   end

   assign wp_cur = byp_hit_ff ? byp_data_ff : ram_q;

   // reach test: waypoint while navigating, (0,0,z) when heading home
   point_type reach_target;
   logic      reached;

   always_comb begin
      reach_target = wp_cur;
      if (phase_ff == PH_HOME) begin
         reach_target.x = '0;
         reach_target.y = '0;
         reach_target.z = in_pos_ff.z;
      end
   end

   wms_reach u_reach (
      .target    (reach_target),
      .position  (in_pos_ff),
      .radius_sq (cfg_radius_sq_ff),
      .reached   (reached)
   );

   // ------------------------------------------------------------------
   // Step logic: at most one word per advance
   // ------------------------------------------------------------------
   logic      has_result;
   kind_type  res_kind;
   point_type res_set;

   always_comb begin
      phase_in   = phase_ff;
      issued_in  = issued_ff;
      index_in   = index_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      has_result = 1'b0;
      res_kind   = KIND_XYZ;
      res_set    = '0;
      if (advance) begin
         case (in_cmd_ff)
            CMD_CLEAR: begin
               count_in  = '0;
               index_in  = '0;
               issued_in = 1'b0;
            end
            CMD_APPEND: begin
               // drop the waypoint when the list is full
               if (count_ff < WP_LIMIT) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + IDX_W'(1);
               end
            end
            CMD_ACTIVATE: begin
               phase_in  = PH_TAKEOFF;
               index_in  = '0;
               issued_in = 1'b0;
            end
            CMD_TICK: begin
               case (phase_ff)
                  PH_TAKEOFF: begin
                     // altitude setpoint only on the first tick
                     issued_in = 1'b1;
                     if (in_pos_ff.z <= cfg_done_z_ff) begin
                        phase_in = PH_NAV;
                     end
                     if (!issued_ff) begin
                        has_result = 1'b1;
                        res_kind   = KIND_ALT;
                        res_set.z  = cfg_target_z_ff;
                     end
                  end
                  PH_NAV: begin
                     if (index_ff < count_ff) begin
                        if (reached) begin
                           index_in = index_ff + IDX_W'(1);
                        end
                        has_result = 1'b1;
                        res_kind   = KIND_XYZ;
                        res_set    = wp_cur;
                     end else begin
                        // list exhausted: head home, no word this tick
                        phase_in = PH_HOME;
                     end
                  end
                  PH_HOME: begin
                     if (reached) begin
                        phase_in = PH_LAND;
                     end
                     has_result = 1'b1;
                     res_kind   = KIND_XYZ;
                     res_set.z  = in_pos_ff.z;
                  end
                  PH_LAND: begin
                     if (in_landed_ff) begin
                        phase_in = PH_DONE;
                     end
                     has_result = 1'b1;
                     res_kind   = KIND_VEL;
                     res_set.z  = cfg_descent_ff;
                  end
                  PH_DONE: begin
                     has_result = 1'b1;
                     res_kind   = KIND_DONE;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         issued_ff <= 1'b0;
         index_ff  <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         issued_ff <= issued_in;
         index_ff  <= index_in;
         count_ff  <= count_in;
      end
   end

   // ------------------------------------------------------------------
   // Result stage: hold the word until the consumer takes it
   // ------------------------------------------------------------------
   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   rsp_kind_ff;
   point_type  rsp_set_ff;
   logic [2:0] rsp_phase_ff;
   logic [4:0] rsp_index_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_kind_ff  <= res_kind;
         rsp_set_ff   <= res_set;
         rsp_phase_ff <= phase_code(phase_in);
         rsp_index_ff <= 5'(index_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_set_x         = rsp_set_ff.x;
   assign rsp_set_y         = rsp_set_ff.y;
   assign rsp_set_z         = rsp_set_ff.z;
   assign rsp_phase         = rsp_phase_ff;
   assign rsp_current_index = rsp_index_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_index_in_list: assert property (@(posedge clock) disable iff (reset)
      index_ff <= count_ff)
      else $error("target index beyond waypoint count");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= WP_LIMIT)
      else $error("waypoint count beyond capacity");

   a_takeoff_once: assert property (@(posedge clock) disable iff (reset)
      (advance && in_cmd_ff == CMD_TICK && phase_ff == PH_TAKEOFF) |=> issued_ff)
      else $error("takeoff flag not set after takeoff tick");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (advance && has_result) |=> rsp_valid_ff)
      else $error("result word lost");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !advance)
      else $error("input stage advanced over a held result");

endmodule

/* hw/rtl/wms_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/wms_reach.sv */
// Squared-distance acceptance test against the configured radius.
`timescale 1ns / 1ps

module wms_reach (
   input  wms_pkg::point_type                  target,
   input  wms_pkg::point_type                  position,
   input  logic [wms_pkg::RADIUS_W-1:0]        radius_sq,
   output logic                                reached
);
   import wms_pkg::*;

   localparam int DIFF_W = COORD_W + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int SUM_W  = SQ_W + 2;

   logic signed [DIFF_W-1:0] dx, dy, dz;
   logic [DIFF_W-1:0]        mx, my, mz;
   logic [SQ_W-1:0]          sx, sy, sz;
   logic [SUM_W-1:0]         dist_sq;

   // signed differences, then magnitudes, so the squares stay unsigned
   assign dx = {target.x[COORD_W-1], target.x} - {position.x[COORD_W-1], position.x};
   assign dy = {target.y[COORD_W-1], target.y} - {position.y[COORD_W-1], position.y};
   assign dz = {target.z[COORD_W-1], target.z} - {position.z[COORD_W-1], position.z};

   assign mx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
   assign my = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
   assign mz = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);

   assign sx = mx * mx;
   assign sy = my * my;
   assign sz = mz * mz;

   assign dist_sq = SUM_W'(sx) + SUM_W'(sy) + SUM_W'(sz);
   assign reached = dist_sq < SUM_W'(radius_sq);

endmodule
